FILE: src/skl_pkg.sv
package skl_pkg;

    // Table size and key width
    localparam int CAPACITY = 64;
    localparam int KEY_BITS = 20;
    // Count must hold the value CAPACITY itself
    localparam int CNT_BITS = $clog2(CAPACITY + 1);

    typedef logic [KEY_BITS-1:0] t_key;
    typedef logic [CNT_BITS-1:0] t_count;

    // Item codes
    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    // Data handed from one slot to the next one up
    typedef struct packed {
        logic ge;   // this slot lies at or past the insert point
        t_key key;  // key held in this slot
    } t_link;

    // Control broadcast from the top level to the chain
    typedef struct packed {
        logic   we;     // shift-insert this cycle
        t_key   key;    // key of the item in progress
        t_count count;  // entries held before this item
    } t_chain_ctl;

endpackage

FILE: src/skl_cell.sv
module skl_cell
    import skl_pkg::*;
(
    input  logic  i_clk,
    input  t_key  i_key,
    input  logic  i_occ,
    input  logic  i_we,
    input  t_link i_prev,
    output t_link o_link,
    output logic  o_match
);

    t_key r_key;
    t_key n_key;

    // Slot is past the insert point when empty or holding a larger key
    assign o_link.ge  = !i_occ || (r_key > i_key);
    assign o_link.key = r_key;
    assign o_match    = i_occ && (r_key == i_key);

    // First slot past the point takes the new key, the ones above shift up
    always_comb begin
        n_key = r_key;
        if (o_link.ge) begin
            n_key = i_prev.ge ? i_prev.key : i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_key <= n_key;
        end
    end

endmodule

FILE: src/skl_chain.sv
module skl_chain
    import skl_pkg::*;
(
    input  logic       i_clk,
    input  t_chain_ctl i_ctl,
    output logic       o_found
);

    t_link               w_link [CAPACITY+1];
    logic [CAPACITY-1:0] w_match;

    // Below slot 0 nothing is past the insert point
    assign w_link[0].ge  = 1'b0;
    assign w_link[0].key = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
        logic w_occ;
        assign w_occ = i_ctl.count > t_count'(g);

        skl_cell u_slot (
            .i_clk   (i_clk),
            .i_key   (i_ctl.key),
            .i_occ   (w_occ),
            .i_we    (i_ctl.we),
            .i_prev  (w_link[g]),
            .o_link  (w_link[g+1]),
            .o_match (w_match[g])
        );
    end

    // Exact membership over all occupied slots
    assign o_found = |w_match;

endmodule

FILE: src/sorted_key_set_lookup_insert.sv
// Channel | Direction | Handshake          | Payload
// --------+-----------+--------------------+------------------------------------
// in      | input     | i_valid / o_stall  | i_action, i_key
// out     | output    | o_valid / i_stall  | o_found, o_rejected, o_entries
//
// Each item is first captured, then processed in a step in which every slot of
// the chain compares against the key in parallel and, for an insert, shifts up.
// A new item is taken once the previous one has moved to the output register.
// A stalled output holds the item in progress until the output register frees.
// Reset clears the entry count and handshake state; slot contents are not reset.
module sorted_key_set_lookup_insert
    import skl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [19:0] i_key,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_found,
    output logic        o_rejected,
    output logic [6:0]  o_entries
);

    logic       r_busy;
    logic       r_act;
    t_key       r_key;
    t_count     r_count;
    logic       r_out_valid;
    logic       r_found;
    logic       r_rejected;

    logic       w_accept;
    logic       w_process;
    logic       w_full;
    logic       w_found;
    t_chain_ctl w_ctl;

    // Handshake
    assign o_stall   = r_busy;
    assign w_accept  = i_valid && !r_busy;
    assign w_process = r_busy && (!r_out_valid || !i_stall);
    assign w_full    = r_count == t_count'(CAPACITY);

    assign w_ctl.we    = w_process && (r_act == ACT_INSERT) && !w_full;
    assign w_ctl.key   = r_key;
    assign w_ctl.count = r_count;

    skl_chain u_chain (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .o_found (w_found)
    );

    // Item capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act <= i_action;
            r_key <= i_key[KEY_BITS-1:0];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_process) begin
                r_busy <= 1'b0;
            end
            if (w_ctl.we) begin
                r_count <= r_count + t_count'(1);
            end
            if (w_process) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_process) begin
            r_found    <= w_found;
            r_rejected <= (r_act == ACT_INSERT) && w_full;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_found    = r_found;
    assign o_rejected = r_rejected;
    assign o_entries  = 7'(r_count);

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(CAPACITY))
        else $error("entry count above capacity");

    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rejected |-> r_count == t_count'(CAPACITY))
        else $error("reject reported while table not full");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.we |=> r_count == $past(r_count) + t_count'(1))
        else $error("insert did not advance count");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_busy)
        else $error("accepted item not in progress");

endmodule
